// ===== src/plc_request_frame_builder_macros.svh =====
// assertion macros shared by the frame builder rtl
`ifndef PLC_REQUEST_FRAME_BUILDER_MACROS_SVH
`define PLC_REQUEST_FRAME_BUILDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame builder: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame builder: next-cycle check failed");

`endif

// ===== src/plc_rfb_pkg.sv =====
// package with codes, constants and job types of the request frame builder
`timescale 1ns / 1ps

package plc_rfb_pkg;

    // command selector codes
    localparam logic [1:0] CmdRead  = 2'd0;
    localparam logic [1:0] CmdWrite = 2'd1;
    localparam logic [1:0] CmdData  = 2'd2;
    localparam logic [1:0] CmdBad   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CfgNetwork   = 2'd0;
    localparam logic [1:0] CfgStation   = 2'd1;
    localparam logic [1:0] CfgDestIo    = 2'd2;
    localparam logic [1:0] CfgMultidrop = 2'd3;

    localparam logic [4:0]  LastHdrIdx  = 5'd20;
    localparam logic [15:0] BaseReqLen  = 16'd12;
    localparam logic [15:0] MaxWriteLen = 16'hFFFF - BaseReqLen;

    // per-header settings from the configuration registers
    typedef struct packed {
        logic [7:0]  network;
        logic [7:0]  station;
        logic [15:0] dest_io;
        logic [7:0]  multidrop;
    } t_hdr_cfg;

    // one decoded item waiting to be serialized
    typedef struct packed {
        logic        is_hdr;
        logic        is_write;
        logic [7:0]  single_byte;
        logic        single_last;
        logic        single_rej;
        logic [15:0] timer;
        logic [23:0] head;
        logic [7:0]  dev;
        logic [15:0] points;
        logic [15:0] reqlen;
        logic        hdr_last;
    } t_job;

endpackage

// ===== src/plc_request_frame_builder.sv =====
// top level of the 3e binary request frame builder
`timescale 1ns / 1ps

// Builds 3E binary batch word read/write request frames as a byte stream.
// A read or write header word (tuser 0 or 1) expands into the 21 header bytes;
// after a write header, write_length data words (tuser 2) pass their byte
// straight through, and the final byte of the frame carries tlast. A header
// while data is still pending, a data word with none pending, selector 3 or
// a write_length above 65523 each give one output word with tuser (rejected)
// set, tdata 0 and tlast 0; the pending count is left alone.
// A data byte or a rejected word gives one output byte, a header gives 21,
// stepped out by the header byte counter in front of the output register.
// A new word is taken in the cycle the previous job hands its last byte to
// the output register; while the output is stalled the job register holds
// and the input waits with it. Configuration is sampled while the header
// bytes go out and should only be written while the block is idle.
module plc_request_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // from lsb: monitor_timer[15:0], start_device[39:16], device_kind[47:40],
    // point_count[63:48], write_length[79:64], data_byte[87:80]
    input  logic [87:0] s_axis_tdata,
    // from lsb: command[1:0]
    input  logic [1:0]  s_axis_tuser,
    // frame bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // from lsb: frame_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // from lsb: rejected[0]
    output logic        m_axis_tuser
);
    import plc_rfb_pkg::*;
    `include "plc_request_frame_builder_macros.svh"

    // configuration registers
    t_hdr_cfg    r_cfg;

    // write data bytes still expected after a write header
    logic [15:0] r_data_remaining;
    logic [15:0] n_data_remaining;

    // job register between decode and the output register
    logic        r_job_valid;
    t_job        r_job;
    logic [4:0]  r_idx;
    t_job        n_job;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_rej;

    logic        w_accept;
    logic        w_out_adv;
    logic        w_emit;
    logic        w_job_done;
    logic [7:0]  w_hdr_byte;
    logic        w_hdr_last;

    plc_rfb_decode u_decode (
        .i_cmd       (s_axis_tuser),
        .i_timer     (s_axis_tdata[15:0]),
        .i_head      (s_axis_tdata[39:16]),
        .i_dev       (s_axis_tdata[47:40]),
        .i_points    (s_axis_tdata[63:48]),
        .i_wlen      (s_axis_tdata[79:64]),
        .i_dbyte     (s_axis_tdata[87:80]),
        .i_remaining (r_data_remaining),
        .o_job       (n_job),
        .o_remaining (n_data_remaining)
    );

    plc_rfb_hdr_mux u_hdr_mux (
        .i_job  (r_job),
        .i_cfg  (r_cfg),
        .i_idx  (r_idx),
        .o_byte (w_hdr_byte),
        .o_last (w_hdr_last)
    );

    // output register takes a byte when empty or being drained
    assign w_out_adv  = !r_out_valid || m_axis_tready;
    assign w_emit     = r_job_valid && w_out_adv;
    // single-byte jobs end at once, headers at their last byte
    assign w_job_done = !r_job.is_hdr || (r_idx == LastHdrIdx);

    assign s_axis_tready = !r_job_valid || (w_out_adv && w_job_done);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.network    <= 8'd0;
            r_cfg.station    <= 8'd255;
            r_cfg.dest_io    <= 16'd1023;
            r_cfg.multidrop  <= 8'd0;
            r_data_remaining <= 16'd0;
            r_job_valid      <= 1'b0;
            r_idx            <= 5'd0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgNetwork:   r_cfg.network   <= i_cfg_data[7:0];
                    CfgStation:   r_cfg.station   <= i_cfg_data[7:0];
                    CfgDestIo:    r_cfg.dest_io   <= i_cfg_data;
                    CfgMultidrop: r_cfg.multidrop <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // job register and byte counter
            if (w_accept) begin
                r_job_valid      <= 1'b1;
                r_idx            <= 5'd0;
                r_data_remaining <= n_data_remaining;
            end else if (w_emit) begin
                if (w_job_done) begin
                    r_job_valid <= 1'b0;
                    r_idx       <= 5'd0;
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end

            if (w_out_adv) begin
                r_out_valid <= r_job_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= n_job;
        end
        if (w_emit) begin
            if (r_job.is_hdr) begin
                r_out_byte <= w_hdr_byte;
                r_out_last <= w_hdr_last;
                r_out_rej  <= 1'b0;
            end else begin
                r_out_byte <= r_job.single_byte;
                r_out_last <= r_job.single_last;
                r_out_rej  <= r_job.single_rej;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_rej;

    // byte counter only moves inside a header job and stays in range
    `PLC_ASSERT_IMPL(a_idx_in_hdr, r_job_valid && r_idx != 5'd0, r_job.is_hdr)
    `PLC_ASSERT_IMPL(a_idx_range, r_job_valid, r_idx <= LastHdrIdx)
    // an accepted write header loads the pending data count
    `PLC_ASSERT_NEXT(a_rem_load, w_accept && n_job.is_hdr && n_job.is_write,
                     r_data_remaining == $past(s_axis_tdata[79:64]))
    // a rejected word never marks the end of a frame
    `PLC_ASSERT_IMPL(a_rej_not_last, r_out_valid && r_out_rej, !r_out_last)

endmodule

// ===== src/plc_rfb_decode.sv =====
// item decode: checks an incoming word against pending data and builds a job
`timescale 1ns / 1ps

module plc_rfb_decode (
    input  logic [1:0]          i_cmd,
    input  logic [15:0]         i_timer,
    input  logic [23:0]         i_head,
    input  logic [7:0]          i_dev,
    input  logic [15:0]         i_points,
    input  logic [15:0]         i_wlen,
    input  logic [7:0]          i_dbyte,
    input  logic [15:0]         i_remaining,
    output plc_rfb_pkg::t_job   o_job,
    output logic [15:0]         o_remaining
);
    import plc_rfb_pkg::*;

    logic        w_pending;
    logic [15:0] w_wlen;

    assign w_pending = (i_remaining != 16'd0);
    assign w_wlen    = (i_cmd == CmdRead) ? 16'd0 : i_wlen;

    always_comb begin
        o_job             = '0;
        o_job.timer       = i_timer;
        o_job.head        = i_head;
        o_job.dev         = i_dev;
        o_job.points      = i_points;
        o_job.is_write    = (i_cmd == CmdWrite);
        o_job.reqlen      = BaseReqLen + w_wlen;
        o_job.hdr_last    = (w_wlen == 16'd0);
        o_remaining       = i_remaining;
        priority if (i_cmd == CmdData) begin
            if (!w_pending) begin
                o_job.single_rej = 1'b1;
            end else begin
                o_job.single_byte = i_dbyte;
                o_job.single_last = (i_remaining == 16'd1);
                o_remaining       = i_remaining - 16'd1;
            end
        end else if (i_cmd == CmdBad || w_pending) begin
            o_job.single_rej = 1'b1;
        end else if (i_cmd == CmdWrite && i_wlen > MaxWriteLen) begin
            o_job.single_rej = 1'b1;
        end else begin
            o_job.is_hdr = 1'b1;
            o_remaining  = w_wlen;
        end
    end

endmodule

// ===== src/plc_rfb_hdr_mux.sv =====
// header byte select: picks one of the 21 header bytes by position
`timescale 1ns / 1ps

module plc_rfb_hdr_mux (
    input  plc_rfb_pkg::t_job     i_job,
    input  plc_rfb_pkg::t_hdr_cfg i_cfg,
    input  logic [4:0]            i_idx,
    output logic [7:0]            o_byte,
    output logic                  o_last
);
    import plc_rfb_pkg::*;

    always_comb begin
        unique case (i_idx)
            5'd0:    o_byte = 8'h50;
            5'd1:    o_byte = 8'h00;
            5'd2:    o_byte = i_cfg.network;
            5'd3:    o_byte = i_cfg.station;
            5'd4:    o_byte = i_cfg.dest_io[7:0];
            5'd5:    o_byte = i_cfg.dest_io[15:8];
            5'd6:    o_byte = i_cfg.multidrop;
            5'd7:    o_byte = i_job.reqlen[7:0];
            5'd8:    o_byte = i_job.reqlen[15:8];
            5'd9:    o_byte = i_job.timer[7:0];
            5'd10:   o_byte = i_job.timer[15:8];
            5'd11:   o_byte = 8'h01;
            5'd12:   o_byte = i_job.is_write ? 8'h14 : 8'h04;
            5'd13:   o_byte = 8'h00;
            5'd14:   o_byte = 8'h00;
            5'd15:   o_byte = i_job.head[7:0];
            5'd16:   o_byte = i_job.head[15:8];
            5'd17:   o_byte = i_job.head[23:16];
            5'd18:   o_byte = i_job.dev;
            5'd19:   o_byte = i_job.points[7:0];
            5'd20:   o_byte = i_job.points[15:8];
            default: o_byte = 8'h00;
        endcase
    end

    // only a frame with no write data ends on the header
    assign o_last = (i_idx == LastHdrIdx) && i_job.hdr_last;

endmodule

// ===== tb/testbench.sv =====
// self-checking stream testbench for the 3e binary request frame builder
`timescale 1ns / 1ps

module testbench;
    import plc_rfb_pkg::*;

    // no word moving on either side for this many cycles while work is open ends the run
    localparam int StallLimit   = 4000;
    // settle time after the last expected byte
    localparam int SettleCycles = 40;

    // one request word as the sender sees it
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] timer;
        logic [23:0] head;
        logic [7:0]  dev;
        logic [15:0] points;
        logic [15:0] wlen;
        logic [7:0]  dbyte;
    } t_request_word;

    // one frame byte as the receiver sees it
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       rej;
    } t_frame_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = CfgNetwork;
    logic [15:0] i_cfg_data    = 16'h0000;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // from lsb: monitor_timer, start_device, device_kind, point_count, write_length, data_byte
    logic [87:0] s_axis_tdata  = '0;
    // from lsb: command
    logic [1:0]  s_axis_tuser  = CmdRead;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // from lsb: frame_byte
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    // from lsb: rejected
    logic        m_axis_tuser;

    // requests waiting for the driver, and frame bytes waiting for the monitor
    t_request_word request_queue[$];
    t_frame_word   expected_bytes[$];
    t_request_word driven_word;

    // shadow of the block's settings and pending write count
    logic [7:0]  cfg_network   = 8'd0;
    logic [7:0]  cfg_station   = 8'd255;
    logic [15:0] cfg_dest_io   = 16'd1023;
    logic [7:0]  cfg_multidrop = 8'd0;
    logic [15:0] data_left     = 16'd0;

    // idle chance in percent for each side
    int unsigned send_idle_pct = 7;
    int unsigned recv_idle_pct = 71;

    int errors      = 0;
    int stall_count = 0;

    plc_request_frame_builder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    // frame bytes that one accepted request word must produce
    function automatic void predict_frame(input t_request_word w);
        logic [7:0]  hdr [0:20];
        logic [15:0] wlen;
        logic [15:0] reqlen;
        if (w.cmd == CmdData) begin
            if (data_left == 16'd0) begin
                // data word with no write header open
                expected_bytes.push_back('{8'h00, 1'b0, 1'b1});
            end else begin
                data_left = data_left - 16'd1;
                expected_bytes.push_back('{w.dbyte, data_left == 16'd0, 1'b0});
            end
        end else if (w.cmd == CmdBad || data_left != 16'd0 ||
                     (w.cmd == CmdWrite && w.wlen > MaxWriteLen)) begin
            // unknown selector, header during a data run, or request length overflow
            expected_bytes.push_back('{8'h00, 1'b0, 1'b1});
        end else begin
            wlen   = (w.cmd == CmdRead) ? 16'd0 : w.wlen;
            reqlen = BaseReqLen + wlen;
            hdr[0]  = 8'h50;
            hdr[1]  = 8'h00;
            hdr[2]  = cfg_network;
            hdr[3]  = cfg_station;
            hdr[4]  = cfg_dest_io[7:0];
            hdr[5]  = cfg_dest_io[15:8];
            hdr[6]  = cfg_multidrop;
            hdr[7]  = reqlen[7:0];
            hdr[8]  = reqlen[15:8];
            hdr[9]  = w.timer[7:0];
            hdr[10] = w.timer[15:8];
            hdr[11] = 8'h01;
            hdr[12] = (w.cmd == CmdRead) ? 8'h04 : 8'h14;
            hdr[13] = 8'h00;
            hdr[14] = 8'h00;
            hdr[15] = w.head[7:0];
            hdr[16] = w.head[15:8];
            hdr[17] = w.head[23:16];
            hdr[18] = w.dev;
            hdr[19] = w.points[7:0];
            hdr[20] = w.points[15:8];
            for (int i = 0; i <= LastHdrIdx; i++) begin
                expected_bytes.push_back('{hdr[i], (i == LastHdrIdx) && (wlen == 16'd0), 1'b0});
            end
            data_left = wlen;
        end
    endfunction

    // driver: one request word in flight, held until the block takes it
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            predict_frame(driven_word);
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (i_rst_n && request_queue.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                driven_word   <= request_queue[0];
                s_axis_tdata  <= {request_queue[0].dbyte, request_queue[0].wlen,
                                  request_queue[0].points, request_queue[0].dev,
                                  request_queue[0].head, request_queue[0].timer};
                s_axis_tuser  <= request_queue[0].cmd;
                s_axis_tvalid <= 1'b1;
                void'(request_queue.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: every output word against the oldest expected byte
    always @(posedge i_clk) begin
        t_frame_word exp_word;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected word tdata %02h tlast %b tuser %b",
                                          m_axis_tdata, m_axis_tlast, m_axis_tuser));
            end else begin
                exp_word = expected_bytes.pop_front();
                if (m_axis_tdata !== exp_word.value)
                    report_mismatch($sformatf("frame byte %02h, expected %02h",
                                              m_axis_tdata, exp_word.value));
                if (m_axis_tlast !== exp_word.last)
                    report_mismatch($sformatf("tlast %b, expected %b",
                                              m_axis_tlast, exp_word.last));
                if (m_axis_tuser !== exp_word.rej)
                    report_mismatch($sformatf("rejected %b, expected %b",
                                              m_axis_tuser, exp_word.rej));
            end
        end
    end

    // watchdog on a stuck handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (request_queue.size() == 0 && !s_axis_tvalid && expected_bytes.size() == 0)) begin
            stall_count <= 0;
        end else if (stall_count + 1 >= StallLimit) begin
            $display("%0t ns timeout: no word moved for %0d cycles", $time, StallLimit);
            $display("plc_request_frame_builder regression: fail");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic t_request_word make_word(input logic [1:0] cmd, input logic [15:0] timer,
                                                input logic [23:0] head, input logic [7:0] dev,
                                                input logic [15:0] points,
                                                input logic [15:0] wlen,
                                                input logic [7:0] dbyte);
        t_request_word w;
        w = '{cmd, timer, head, dev, points, wlen, dbyte};
        return w;
    endfunction

    // all fields random, command as given
    function automatic t_request_word random_word(input logic [1:0] cmd);
        return make_word(cmd, 16'($urandom), 24'($urandom), 8'($urandom), 16'($urandom),
                         16'($urandom), 8'($urandom));
    endfunction

    // block until every queued word has been taken and every byte has come back
    task automatic wait_drained();
        while (request_queue.size() > 0 || s_axis_tvalid || expected_bytes.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CfgNetwork:   cfg_network   = value[7:0];
            CfgStation:   cfg_station   = value[7:0];
            CfgDestIo:    cfg_dest_io   = value;
            CfgMultidrop: cfg_multidrop = value[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed read and write frames, with some rejected noise mixed in
    task automatic queue_random_requests(input int count);
        int made;
        int sel;
        int nbytes;
        t_request_word w;
        made = 0;
        while (made < count) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                request_queue.push_back(random_word(CmdRead));
                made++;
            end else if (sel < 80) begin
                nbytes = (sel < 40) ? 0 : $urandom_range(12, 1);
                w = random_word(CmdWrite);
                w.wlen = 16'(nbytes);
                request_queue.push_back(w);
                made++;
                for (int i = 0; i < nbytes; i++) begin
                    // a stray header or selector inside the data run
                    if ($urandom_range(99) < 8) begin
                        request_queue.push_back(random_word(2'($urandom_range(3))));
                        made++;
                    end
                    request_queue.push_back(random_word(CmdData));
                    made++;
                end
            end else if (sel < 87) begin
                request_queue.push_back(random_word(CmdData));
                made++;
            end else if (sel < 93) begin
                request_queue.push_back(random_word(CmdBad));
                made++;
            end else begin
                w = random_word(CmdWrite);
                w.wlen = 16'($urandom_range(16'hFFFF, MaxWriteLen + 1));
                request_queue.push_back(w);
                made++;
            end
        end
    endtask

    initial begin
        t_request_word w;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset settings
        request_queue.push_back(make_word(CmdRead, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'h0000, 8'h00));
        request_queue.push_back(make_word(CmdRead, 16'hFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF,
                                          16'hFFFF, 8'hFF));
        // write with no data ends on its last header byte
        request_queue.push_back(make_word(CmdWrite, 16'hFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF,
                                          16'h0000, 8'hFF));
        // data word with no write open, then unknown selector
        request_queue.push_back(make_word(CmdData, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'h0000, 8'hAA));
        request_queue.push_back(make_word(CmdBad, 16'hFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF,
                                          16'hFFFF, 8'hFF));
        // request length overflow, just past the limit and at the top
        request_queue.push_back(make_word(CmdWrite, 16'h1234, 24'h345678, 8'hA8, 16'h0010,
                                          MaxWriteLen + 16'd1, 8'h00));
        request_queue.push_back(make_word(CmdWrite, 16'h1234, 24'h345678, 8'hA8, 16'h0010,
                                          16'hFFFF, 8'h00));
        // write of three bytes with headers and a bad selector refused in between
        request_queue.push_back(make_word(CmdWrite, 16'h0001, 24'h800001, 8'h90, 16'h8001,
                                          16'd3, 8'h00));
        request_queue.push_back(make_word(CmdRead, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'h0000, 8'h00));
        request_queue.push_back(make_word(CmdData, 16'hFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF,
                                          16'hFFFF, 8'h00));
        request_queue.push_back(make_word(CmdWrite, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'd1, 8'h00));
        request_queue.push_back(make_word(CmdBad, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'h0000, 8'h00));
        request_queue.push_back(make_word(CmdData, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'h0000, 8'hFF));
        request_queue.push_back(make_word(CmdData, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'h0000, 8'h5A));
        // one data word too many
        request_queue.push_back(make_word(CmdData, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'h0000, 8'h11));
        request_queue.push_back(make_word(CmdWrite, 16'hA55A, 24'h00FF00, 8'h9C, 16'h0001,
                                          16'd1, 8'h00));
        request_queue.push_back(make_word(CmdData, 16'h0000, 24'h000000, 8'h00, 16'h0000,
                                          16'h0000, 8'h80));
        request_queue.push_back(random_word(CmdRead));
        wait_drained();

        // network, dest_io and multidrop at their top, station at zero; upper data bits set on network and station
        write_cfg(CfgNetwork, 16'hFFFF);
        write_cfg(CfgStation, 16'hFF00);
        write_cfg(CfgDestIo, 16'hFFFF);
        write_cfg(CfgMultidrop, 16'h00FF);
        queue_random_requests(70);
        // sender holds off until the block has emptied
        wait_drained();
        queue_random_requests(70);
        wait_drained();

        // all settings at zero, idling swapped between the sides
        send_idle_pct = 71;
        recv_idle_pct = 7;
        write_cfg(CfgNetwork, 16'h0000);
        write_cfg(CfgStation, 16'h0000);
        write_cfg(CfgDestIo, 16'h0000);
        write_cfg(CfgMultidrop, 16'h0000);
        queue_random_requests(140);
        wait_drained();

        // random settings, no idling, and a write header of the longest allowed length
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(CfgNetwork, 16'($urandom));
        write_cfg(CfgStation, 16'($urandom));
        write_cfg(CfgDestIo, 16'($urandom));
        write_cfg(CfgMultidrop, 16'($urandom));
        queue_random_requests(120);
        w = random_word(CmdWrite);
        w.wlen = MaxWriteLen;
        request_queue.push_back(w);
        // a few of its data bytes, then a read refused while the run is still open
        for (int i = 0; i < 4; i++)
            request_queue.push_back(random_word(CmdData));
        request_queue.push_back(random_word(CmdRead));
        wait_drained();

        if (errors == 0) begin
            $display("plc_request_frame_builder regression: pass");
        end else begin
            $display("plc_request_frame_builder regression: fail");
        end
        $finish;
    end

endmodule

// ===== plc_request_frame_builder.f =====
+incdir+src
src/plc_rfb_pkg.sv
src/plc_rfb_decode.sv
src/plc_rfb_hdr_mux.sv
src/plc_request_frame_builder.sv
tb/testbench.sv
